FILE: rtl/gda_pkg.sv
// Package for the Gregorian date attribute unit: pipeline stage types,
// reciprocal constants and the month tables. No dependencies.
`default_nettype none

package gda_pkg;

    localparam logic [15:0] FIRST_YEAR_RESET = 16'd1582;
    localparam logic [17:0] RECIP100         = 18'd167772;   // floor(2^24 / 100)
    localparam logic [11:0] RECIP7           = 12'd2340;     // floor(2^14 / 7)
    localparam logic [10:0] WEEK_BIAS        = 11'd1400;     // 200 weeks, keeps sum positive
    localparam logic [3:0]  LAST_MONTH       = 4'd11;
    localparam logic [3:0]  FEBRUARY         = 4'd1;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [15:0] y;
        logic [16:0] zy;
        logic [3:0]  zm;
        logic        yge;
        logic [33:0] py;
        logic [33:0] pz;
    } s1_t;

    typedef struct packed {
        logic [4:0] d;
        logic [3:0] m;
        logic [3:0] zm;
        logic       yge;
        logic       leap;
        logic [6:0] a;
        logic [9:0] b;
    } s2_t;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [4:0]  len;
        logic [8:0]  yd;
        logic [10:0] t;
    } s3_t;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [4:0]  len;
        logic [8:0]  yd;
        logic [8:0]  ym1;
        logic [10:0] t;
        logic [22:0] pt;
        logic [20:0] pw;
    } s4_t;

    function automatic logic [4:0] month_days_f(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd1:                     r = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] days_before_f(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // (13 * zm - 1) / 5 for zm = 1 (March) .. 12 (February)
    function automatic logic [4:0] zeller_month_f(input logic [3:0] zm);
        logic [4:0] r;
        unique case (zm)
            4'd1:    r = 5'd2;
            4'd2:    r = 5'd5;
            4'd3:    r = 5'd7;
            4'd4:    r = 5'd10;
            4'd5:    r = 5'd12;
            4'd6:    r = 5'd15;
            4'd7:    r = 5'd18;
            4'd8:    r = 5'd20;
            4'd9:    r = 5'd23;
            4'd10:   r = 5'd25;
            4'd11:   r = 5'd28;
            4'd12:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gregorian_date_attributes_unit.sv
// Top level of the Gregorian date attribute unit: five-stage pipeline.
// Depends on gda_pkg for stage types, constants and month tables.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one date word: day_in,
//   month_in (0 = January) and year_in. Output channel (out_valid /
//   out_stall) carries one attribute word per date: date_valid, leap,
//   month_length, weekday (1 = Sunday), is_weekend, year_day, week_number.
//   A word moves when valid is high and stall is low.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes
//   first_valid_year; cfg_ready is always high. Write only while idle.
//   A date passes five register stages, s1 to s4 and the output registers,
//   to reach the output. Throughput: one date per cycle unless the
//   output is stalled; each multiply by a reciprocal has its
//   own stage, and the remainder correction that follows it the next.
//   Reset clears all stage valid bits and loads first_valid_year = 1582.
//   While the output word is stalled the whole pipeline holds and in_stall
//   is raised; nothing is dropped or repeated.
`default_nettype none

module gregorian_date_attributes_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [4:0]  day_in,
    input  wire logic [3:0]  month_in,
    input  wire logic [15:0] year_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             date_valid,
    output logic             leap,
    output logic [4:0]       month_length,
    output logic [2:0]       weekday,
    output logic             is_weekend,
    output logic [8:0]       year_day,
    output logic [5:0]       week_number,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import gda_pkg::*;

    logic        adv;
    logic [15:0] first_year_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    s3_t         s3_reg, s3_next;
    s4_t         s4_reg, s4_next;

    logic        o_valid_reg, o_valid_next;
    logic        o_leap_reg, o_leap_next;
    logic [4:0]  o_len_reg, o_len_next;
    logic [2:0]  o_wd_reg, o_wd_next;
    logic        o_wkend_reg, o_wkend_next;
    logic [8:0]  o_yd_reg, o_yd_next;
    logic [5:0]  o_week_reg, o_week_next;

    assign adv       = !(v5_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_year_reg <= FIRST_YEAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            first_year_reg <= cfg_data;
        end
    end

    // Stage 1: Zeller month and year, reciprocal products for /100
    always_comb
    begin
        s1_next.d   = day_in;
        s1_next.m   = month_in;
        s1_next.y   = year_in;
        s1_next.zm  = (month_in < 4'd2) ? month_in + 4'd11 : month_in - 4'd1;
        s1_next.zy  = 17'(year_in) + 17'd400 - 17'((month_in < 4'd2) ? 1 : 0);
        s1_next.yge = (year_in >= first_year_reg);
        s1_next.py  = 34'(year_in) * 34'(RECIP100);
        s1_next.pz  = 34'(s1_next.zy) * 34'(RECIP100);
    end

    // Stage 2: correct quotients and remainders, leap flag, Zeller a and b
    always_comb
    begin
        logic [9:0]  qy, qz;
        logic [16:0] ry_full, rz_full;
        logic [7:0]  ry, rz;
        logic        cy, cz;
        qy      = s1_reg.py[33:24];
        qz      = s1_reg.pz[33:24];
        ry_full = 17'(s1_reg.y) - 17'(qy) * 17'd100;
        rz_full = s1_reg.zy - 17'(qz) * 17'd100;
        cy      = (ry_full[7:0] >= 8'd100);
        cz      = (rz_full[7:0] >= 8'd100);
        ry      = cy ? ry_full[7:0] - 8'd100 : ry_full[7:0];
        rz      = cz ? rz_full[7:0] - 8'd100 : rz_full[7:0];
        qy      = qy + 10'(cy);
        qz      = qz + 10'(cz);
        s2_next.d    = s1_reg.d;
        s2_next.m    = s1_reg.m;
        s2_next.zm   = s1_reg.zm;
        s2_next.yge  = s1_reg.yge;
        s2_next.leap = (ry == 8'd0) ? (qy[1:0] == 2'd0) : (s1_reg.y[1:0] == 2'd0);
        s2_next.a    = rz[6:0];
        s2_next.b    = qz;
    end

    // Stage 3: month length, validity, day of year, Zeller sum
    always_comb
    begin
        logic [4:0] len;
        len = month_days_f(s2_reg.m) + 5'((s2_reg.m == FEBRUARY && s2_reg.leap) ? 1 : 0);
        s3_next.leap = s2_reg.leap;
        s3_next.len  = len;
        s3_next.ok   = s2_reg.yge && (s2_reg.m <= LAST_MONTH)
                       && (s2_reg.d != 5'd0) && (s2_reg.d <= len);
        s3_next.yd   = days_before_f(s2_reg.m) + 9'(s2_reg.d)
                       + 9'((s2_reg.m > FEBRUARY && s2_reg.leap) ? 1 : 0);
        s3_next.t    = 11'(s2_reg.a[6:2]) + 11'(s2_reg.b[9:2]) + 11'(s2_reg.d)
                       + 11'(s2_reg.a) + 11'(zeller_month_f(s2_reg.zm)) + WEEK_BIAS
                       - 11'({s2_reg.b, 1'b0});
    end

    // Stage 4: reciprocal products for /7
    always_comb
    begin
        s4_next.ok   = s3_reg.ok;
        s4_next.leap = s3_reg.leap;
        s4_next.len  = s3_reg.len;
        s4_next.yd   = s3_reg.yd;
        s4_next.ym1  = s3_reg.yd - 9'd1;
        s4_next.t    = s3_reg.t;
        s4_next.pt   = 23'(s3_reg.t) * 23'(RECIP7);
        s4_next.pw   = 21'(s4_next.ym1) * 21'(RECIP7);
    end

    // Stage 5: correct /7 results, zero fields of invalid dates
    always_comb
    begin
        logic [7:0]  q7;
        logic [5:0]  wq;
        logic [10:0] r7_full;
        logic [8:0]  rw_full;
        logic [3:0]  r7;
        logic [2:0]  wd;
        q7      = s4_reg.pt[21:14];
        wq      = s4_reg.pw[19:14];
        r7_full = s4_reg.t - 11'(q7) * 11'd7;
        rw_full = s4_reg.ym1 - 9'(wq) * 9'd7;
        r7      = (r7_full[3:0] >= 4'd7) ? r7_full[3:0] - 4'd7 : r7_full[3:0];
        wq      = wq + 6'((rw_full[3:0] >= 4'd7) ? 1 : 0);
        wd      = r7[2:0] + 3'd1;
        o_valid_next = s4_reg.ok;
        o_leap_next  = s4_reg.leap;
        o_len_next   = s4_reg.ok ? s4_reg.len : 5'd0;
        o_wd_next    = s4_reg.ok ? wd : 3'd0;
        o_wkend_next = s4_reg.ok && (wd == 3'd1 || wd == 3'd7);
        o_yd_next    = s4_reg.ok ? s4_reg.yd : 9'd0;
        o_week_next  = s4_reg.ok ? wq + 6'd1 : 6'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s4_reg      <= s4_next;
            o_valid_reg <= o_valid_next;
            o_leap_reg  <= o_leap_next;
            o_len_reg   <= o_len_next;
            o_wd_reg    <= o_wd_next;
            o_wkend_reg <= o_wkend_next;
            o_yd_reg    <= o_yd_next;
            o_week_reg  <= o_week_next;
        end
    end

    assign out_valid    = v5_reg;
    assign date_valid   = o_valid_reg;
    assign leap         = o_leap_reg;
    assign month_length = o_len_reg;
    assign weekday      = o_wd_reg;
    assign is_weekend   = o_wkend_reg;
    assign year_day     = o_yd_reg;
    assign week_number  = o_week_reg;

endmodule

`default_nettype wire

FILE: tb/gregorian_date_attributes_unit_tb.sv
// Testbench for gregorian_date_attributes_unit: directed and random dates under several
// first-valid-year settings, random sender gaps and receiver stalls, one long output hold.
// Depends on gda_pkg and the unit's RTL; every attribute word is checked against a local model.
`timescale 1ns / 100ps

module gregorian_date_attributes_unit_tb;

    import gda_pkg::*;

    typedef struct packed {
        logic       date_valid;
        logic       leap;
        logic [4:0] month_length;
        logic [2:0] weekday;
        logic       is_weekend;
        logic [8:0] year_day;
        logic [5:0] week_number;
    } date_attr_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [15:0] year_in;
    logic        out_valid;
    logic        out_stall;
    logic        date_valid;
    logic        leap;
    logic [4:0]  month_length;
    logic [2:0]  weekday;
    logic        is_weekend;
    logic [8:0]  year_day;
    logic [5:0]  week_number;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    date_attr_t  expected_attrs[$];
    logic [15:0] first_year_model = FIRST_YEAR_RESET;

    int mismatches     = 0;
    int dates_sent     = 0;
    int valid_dates    = 0;
    int words_checked  = 0;
    int settings_used  = 1;
    bit gaps_on        = 1'b1;
    int burst_left     = 0;
    int rx_mode        = 1;
    int long_hold_req  = 0;

    gregorian_date_attributes_unit uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .day_in       (day_in),
        .month_in     (month_in),
        .year_in      (year_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .date_valid   (date_valid),
        .leap         (leap),
        .month_length (month_length),
        .weekday      (weekday),
        .is_weekend   (is_weekend),
        .year_day     (year_day),
        .week_number  (week_number),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit gregorian_leap(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_len(input int m, input int y);
        int r;
        case (m)
            1:            r = gregorian_leap(y) ? 29 : 28;
            3, 5, 8, 10:  r = 30;
            default:      r = (m > 11) ? 0 : 31;
        endcase
        return r;
    endfunction

    function automatic int zeller_weekday(input int d, input int m, input int y);
        int zm;
        int zy;
        int a;
        int b;
        int r;
        zm = (m + 10) % 12 + 1;
        zy = y + 400 - zm / 11;
        a  = zy % 100;
        b  = zy / 100;
        r  = a / 4 + b / 4 + d + a - 2 * b + (13 * zm - 1) / 5;
        return ((r % 7) + 7) % 7 + 1;
    endfunction

    function automatic date_attr_t date_attributes_of(input logic [4:0] d, input logic [3:0] m,
                                                      input logic [15:0] y);
        date_attr_t r;
        int len;
        int yd;
        int wd;
        int i;
        r      = '0;
        r.leap = gregorian_leap(y);
        len    = month_len(m, y);
        if (y >= first_year_model && m <= 4'd11 && d >= 5'd1 && d <= len)
        begin
            wd = zeller_weekday(d, m, y);
            yd = d;
            for (i = 0; i < m; i++)
                yd += month_len(i, y);
            r.date_valid   = 1'b1;
            r.month_length = len[4:0];
            r.weekday      = wd[2:0];
            r.is_weekend   = (wd == 1 || wd == 7);
            r.year_day     = yd[8:0];
            r.week_number  = 6'((yd - 1) / 7 + 1);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0d expected %0d",
                                      words_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin
        date_attr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_attrs.size() == 0)
                report_mismatch("attribute word with no date outstanding");
            else
            begin
                want = expected_attrs.pop_front();
                check_field("date_valid", 16'(date_valid), 16'(want.date_valid));
                check_field("leap", 16'(leap), 16'(want.leap));
                check_field("month_length", 16'(month_length), 16'(want.month_length));
                check_field("weekday", 16'(weekday), 16'(want.weekday));
                check_field("is_weekend", 16'(is_weekend), 16'(want.is_weekend));
                check_field("year_day", 16'(year_day), 16'(want.year_day));
                check_field("week_number", 16'(week_number), 16'(want.week_number));
            end
            words_checked++;
        end
    end

    // receiver: long hold first, then the current stall pattern
    initial
    begin : receiver
        int  hold_left;
        int  run;
        bit  stall_state;
        hold_left   = 0;
        run         = 0;
        stall_state = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && long_hold_req > 0)
            begin
                hold_left     = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                case (rx_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        if (run == 0)
                        begin
                            stall_state = ~stall_state;
                            run = stall_state ? $urandom_range(1, 6) : $urandom_range(1, 12);
                        end
                        run--;
                        out_stall <= stall_state;
                    end
                endcase
            end
        end
    end

    task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [15:0] y);
        date_attr_t want;
        int gap;
        day_in   <= d;
        month_in <= m;
        year_in  <= y;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = date_attributes_of(d, m, y);
        expected_attrs.push_back(want);
        dates_sent++;
        if (want.date_valid)
            valid_dates++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_attrs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_first_year(input logic [15:0] value);
        wait_idle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        first_year_model = value;
        settings_used++;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int year_lo, input int year_hi);
        int          roll;
        int          len;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [15:0] y;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            y    = 16'($urandom_range(year_lo, year_hi));
            if ($urandom_range(0, 3) == 0)
                y = y - 16'(y % (($urandom_range(0, 1) == 0) ? 100 : 400));
            m   = 4'($urandom_range(0, 11));
            len = month_len(m, y);
            d   = 5'($urandom_range(1, len));
            if (roll >= 75 && roll < 87)
            begin
                case ($urandom_range(0, 3))
                    0: d = 5'd0;
                    1: d = 5'(len + 1);
                    2: m = 4'($urandom_range(12, 15));
                    default: y = (year_lo > 0) ? 16'(year_lo - 1) : y;
                endcase
            end
            else if (roll >= 87)
            begin
                d = 5'($urandom_range(0, 31));
                m = 4'($urandom_range(0, 15));
                y = 16'($urandom_range(0, 65535));
            end
            send_date(d, m, y);
        end
    endtask

    task automatic test_default_first_year();
        send_date(5'd31, 4'd11, 16'd1581);
        send_date(5'd1, 4'd0, 16'd1582);
        send_date(5'd15, 4'd9, 16'd1582);
        send_date(5'd0, 4'd0, 16'd1582);
    endtask

    task automatic test_directed_extremes();
        write_first_year(16'd0);
        send_date(5'd0, 4'd0, 16'd0);
        send_date(5'd1, 4'd0, 16'd0);
        send_date(5'd29, 4'd1, 16'd0);
        send_date(5'd31, 4'd11, 16'd0);
        send_date(5'd31, 4'd0, 16'd2000);
        send_date(5'd31, 4'd3, 16'd2000);
        send_date(5'd29, 4'd1, 16'd1900);
        send_date(5'd29, 4'd1, 16'd2000);
        send_date(5'd29, 4'd1, 16'd2024);
        send_date(5'd29, 4'd1, 16'd2023);
        send_date(5'd28, 4'd1, 16'd2023);
        send_date(5'd31, 4'd11, 16'd2024);
        send_date(5'd31, 4'd11, 16'd2023);
        send_date(5'd1, 4'd12, 16'd2024);
        send_date(5'd31, 4'd15, 16'd65535);
        send_date(5'd31, 4'd11, 16'd65535);
        send_date(5'd28, 4'd1, 16'd65535);
        send_date(5'd6, 4'd0, 16'd2024);
        send_date(5'd7, 4'd0, 16'd2024);
        send_date(5'd1, 4'd2, 16'd2024);
    endtask

    task automatic test_last_first_year();
        write_first_year(16'hFFFF);
        send_date(5'd31, 4'd11, 16'd65534);
        send_date(5'd1, 4'd0, 16'd65535);
        random_phase(40, 65500, 65535);
    endtask

    task automatic test_random_first_year();
        int fy;
        fy = $urandom_range(1000, 3000);
        write_first_year(fy[15:0]);
        rx_mode = 2;
        random_phase(100, fy - 50, fy + 500);
    endtask

    task automatic test_full_range_dates();
        write_first_year(16'd0);
        rx_mode = 1;
        random_phase(150, 0, 65535);
    endtask

    task automatic test_back_pressure();
        wait_idle();
        gaps_on       = 1'b0;
        long_hold_req = 300;
        random_phase(40, 1500, 2600);
        gaps_on = 1'b1;
    endtask

    task automatic test_no_idle();
        wait_idle();
        gaps_on = 1'b0;
        rx_mode = 0;
        random_phase(40, 0, 4000);
        gaps_on = 1'b1;
    endtask

    task automatic test_reset_year_again();
        write_first_year(FIRST_YEAR_RESET);
        rx_mode = 2;
        random_phase(50, 1500, 2600);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        day_in    <= '0;
        month_in  <= '0;
        year_in   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_first_year();
        test_directed_extremes();
        test_last_first_year();
        test_random_first_year();
        test_full_range_dates();
        test_back_pressure();
        test_no_idle();
        test_reset_year_again();

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_attrs.size() != 0)
            report_mismatch($sformatf("%0d dates never answered", expected_attrs.size()));
        $display("Sent %0d dates (%0d valid) under %0d first-year settings, checked %0d words,",
                 dates_sent, valid_dates, settings_used, words_checked);
        $display("with random gaps and stalls, one long output hold and an unthrottled stretch.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d dates outstanding", expected_attrs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gda_pkg.sv
rtl/gregorian_date_attributes_unit.sv
tb/gregorian_date_attributes_unit_tb.sv
